### rtl/core/integer_math_unit_defines.svh
// ----------------------------------------------------------------------------
// Integer math unit assertion macros
// Shared property forms for the concurrent checks of the integer math unit.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATH_UNIT_DEFINES_SVH
`define INTEGER_MATH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("integer_math_unit check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("integer_math_unit check failed");

`endif

### rtl/core/imu_pkg.sv
// ----------------------------------------------------------------------------
// Integer math unit package
// Operation codes, sequencer states and limits shared by the unit's modules.
// ----------------------------------------------------------------------------
package imu_pkg;

	// Operation codes carried in the request's tuser.
	localparam logic [1:0] CMD_GCD  = 2'd0;
	localparam logic [1:0] CMD_FACT = 2'd1;
	localparam logic [1:0] CMD_SQRT = 2'd2;

	// Factorial limit and the width of its step counters.
	localparam int unsigned FACT_MAX = 12;
	localparam int unsigned FACT_IW  = 4;

	// Bound on Newton passes and the width of the pass counter.
	localparam int unsigned SQRT_MAX_ITER = 64;
	localparam int unsigned ITER_W        = 7;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD_CHECK,
		ST_GCD_DIV,
		ST_FACT_LOOP,
		ST_FACT_ADD,
		ST_SQRT_CHECK,
		ST_SQRT_DIV,
		ST_DONE
	} state_t;

	// Status of the shared divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/core/imu_div.sv
// ----------------------------------------------------------------------------
// Integer math unit serial divider
// Restoring radix-2 divider: one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module imu_div
	import imu_pkg::*;
#(
	parameter int unsigned W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output div_stat_t    stat,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int unsigned CW = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W+1:0]  diff;
	logic          neg;

	// One trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = {1'b0, shifted} - {2'b00, dvs_q};
		neg     = diff[W+1];
	end

	// Control: busy for W steps, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: the quotient shifts in where the dividend bits shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= neg ? shifted[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~neg};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/core/integer_math_unit.sv
// ----------------------------------------------------------------------------
// Integer math unit
// GCD by Euclid's remainder loop, factorial, and a Newton square root estimate.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the s_ channel: s_tuser holds the operation (0 gcd,
// 1 factorial of operand_a, 2 square root of operand_a), s_tdata holds
// operand_a in the low DATA_WIDTH bits and operand_b above it. One result
// leaves on the m_ channel: m_tdata holds the result, m_tuser the error flag.
// The unit works on one request at a time; s_tready is high only while the
// sequencer is idle. Every division runs through one shared serial divider.
// A finished result waits in the output register while m_tready is low; the
// next request is accepted meanwhile, and its own result waits in the
// sequencer until the output register frees up.
// Reset clears the sequencer and the output valid; no memory needs clearing.
// ----------------------------------------------------------------------------
`include "integer_math_unit_defines.svh"

module integer_math_unit
	import imu_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 31
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// tdata fields from bit 0: operand_a, operand_b, zero fill
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
	// tuser fields from bit 0: cmd
	input  logic [1:0]                             s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// tdata fields from bit 0: result, zero fill
	output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_tdata,
	// tuser fields from bit 0: error
	output logic                                   m_tuser
);

	localparam int unsigned W         = DATA_WIDTH;
	localparam int unsigned M_TDATA_W = ((DATA_WIDTH+7)/8)*8;
	localparam int unsigned AW        = W + FACT_IW;

	state_t            state_q;
	state_t            state_d;
	logic [W-1:0]      a_q;
	logic [W-1:0]      b_q;
	logic [W-1:0]      x1_q;
	logic [W-1:0]      x2_q;
	logic [W-1:0]      p_q;
	logic [AW-1:0]     acc_q;
	logic [FACT_IW-1:0] i_q;
	logic [FACT_IW-1:0] j_q;
	logic [ITER_W-1:0] iter_q;
	logic              ovf_q;
	logic [W-1:0]      pend_res_q;
	logic              pend_err_q;
	logic [W-1:0]      res_q;
	logic              err_q;
	logic              out_valid_q;

	logic [W-1:0]      op_a;
	logic [W-1:0]      op_b;
	logic              accept;
	logic              out_free;
	logic              fact_bad;
	logic [W-1:0]      sq_diff;
	logic              sq_stop;
	logic [W:0]        sq_sum;
	logic [W-1:0]      xs;
	logic [AW-1:0]     fsum;
	logic              div_start;
	logic [W-1:0]      div_divisor;
	div_stat_t         div_stat;
	logic [W-1:0]      div_quo;
	logic [W-1:0]      div_rem;

	// Request fields and handshake.
	assign op_a     = s_tdata[W-1:0];
	assign op_b     = s_tdata[2*W-1:W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign fact_bad = (op_a == '0) || (op_a > W'(FACT_MAX));

	// Newton step terms and the shared factorial adder.
	always_comb begin
		sq_diff = (x2_q > x1_q) ? (x2_q - x1_q) : (x1_q - x2_q);
		sq_sum  = {1'b0, x1_q} + {1'b0, x2_q};
		xs      = sq_sum[W:1];
		sq_stop = (sq_diff <= W'(1)) || (iter_q == ITER_W'(SQRT_MAX_ITER)) ||
			(xs == '0);
		fsum    = acc_q + AW'(p_q);
	end

	// Divider operand select: gcd divides by b, the square root by the new x2.
	assign div_divisor = (state_q == ST_GCD_CHECK) ? b_q : xs;

	imu_div #(
		.W (W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (a_q),
		.divisor   (div_divisor),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider start.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (s_tuser)
						CMD_GCD:  state_d = ST_GCD_CHECK;
						CMD_FACT: state_d = fact_bad ? ST_DONE : ST_FACT_LOOP;
						CMD_SQRT: state_d = ST_SQRT_CHECK;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_GCD_CHECK: begin
				if (b_q == '0) begin
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_GCD_DIV;
				end
			end
			ST_GCD_DIV: begin
				if (div_stat.done) begin
					state_d = ST_GCD_CHECK;
				end
			end
			ST_FACT_LOOP: begin
				if (ovf_q || (W'(i_q) > a_q)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_FACT_ADD;
				end
			end
			ST_FACT_ADD: begin
				if (j_q == FACT_IW'(1)) begin
					state_d = ST_FACT_LOOP;
				end
			end
			ST_SQRT_CHECK: begin
				if (sq_stop) begin
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_SQRT_DIV;
				end
			end
			ST_SQRT_DIV: begin
				if (div_stat.done) begin
					state_d = ST_SQRT_CHECK;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Working registers of the three algorithms.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				a_q    <= op_a;
				b_q    <= op_b;
				x1_q   <= op_a >> 1;
				x2_q   <= W'(2);
				iter_q <= '0;
				p_q    <= W'(1);
				i_q    <= FACT_IW'(2);
				ovf_q  <= 1'b0;
				pend_res_q <= '0;
				pend_err_q <= 1'b1;
			end
			ST_GCD_CHECK: begin
				pend_res_q <= a_q;
				pend_err_q <= 1'b0;
			end
			ST_GCD_DIV: begin
				if (div_stat.done) begin
					a_q <= b_q;
					b_q <= div_rem;
				end
			end
			ST_FACT_LOOP: begin
				acc_q      <= '0;
				j_q        <= i_q;
				pend_res_q <= ovf_q ? '0 : p_q;
				pend_err_q <= ovf_q;
			end
			ST_FACT_ADD: begin
				if (j_q == FACT_IW'(1)) begin
					ovf_q <= |fsum[AW-1:W];
					p_q   <= fsum[W-1:0];
					i_q   <= i_q + 1'b1;
				end else begin
					acc_q <= fsum;
					j_q   <= j_q - 1'b1;
				end
			end
			ST_SQRT_CHECK: begin
				pend_res_q <= x1_q;
				pend_err_q <= 1'b0;
				if (!sq_stop) begin
					x2_q   <= xs;
					iter_q <= iter_q + 1'b1;
				end
			end
			ST_SQRT_DIV: begin
				if (div_stat.done) begin
					x1_q <= div_quo;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded when a result is done and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			res_q <= pend_res_q;
			err_q <= pend_err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(res_q);
	assign m_tuser  = err_q;

	// Checks on the sequencer and the shared divider.
	`IMU_ASSERT_IMPL(a_idle_div_quiet, clk, arst_n, s_tready, !div_stat.busy)
	`IMU_ASSERT_IMPL(a_div_done_owned, clk, arst_n, div_stat.done,
		(state_q == ST_GCD_DIV) || (state_q == ST_SQRT_DIV))
	`IMU_ASSERT_IMPL(a_error_zero_result, clk, arst_n, m_tvalid && m_tuser, res_q == '0)
	`IMU_ASSERT_NEXT(a_start_busy, clk, arst_n, div_start, div_stat.busy)

endmodule

### dv/imu_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer math unit result checker
// Watches both stream channels of the unit. Every accepted request is turned
// into its expected gcd, factorial or root estimate and queued in order; every
// accepted result is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module imu_result_checker
	import imu_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 31
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	// tdata fields from bit 0: operand_a, operand_b, zero fill
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	// tuser fields from bit 0: cmd
	input  logic [1:0]                        s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// tdata fields from bit 0: result, zero fill
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]   m_tdata,
	// tuser fields from bit 0: error
	input  logic                              m_tuser,
	output int                                mismatch_count,
	output int                                outstanding
);

	// One expected answer, with the request that produced it for messages.
	typedef struct packed {
		logic [1:0]            op;
		logic [DATA_WIDTH-1:0] operand_a;
		logic [DATA_WIDTH-1:0] operand_b;
		logic [DATA_WIDTH-1:0] value;
		logic                  error;
	} answer_t;

	answer_t answer_q[$];
	int      fails   = 0;
	int      pending = 0;

	assign mismatch_count = fails;
	assign outstanding    = pending;

	// Prints one line per mismatch and counts it.
	task automatic note_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fails++;
	endtask

	// Works out the answer the unit must give for one request.
	function automatic answer_t compute_answer(
		input logic [1:0]            op,
		input logic [DATA_WIDTH-1:0] a,
		input logic [DATA_WIDTH-1:0] b
	);
		answer_t         ans;
		longint unsigned x;
		longint unsigned y;
		longint unsigned r;
		longint unsigned wmask;
		int              n;
		logic            settled;
		wmask         = (64'd1 << DATA_WIDTH) - 1;
		ans.op        = op;
		ans.operand_a = a;
		ans.operand_b = b;
		ans.value     = '0;
		ans.error     = 1'b0;
		case (op)
			CMD_GCD: begin
				// Euclid's remainder loop; a zero second operand gives the first.
				x = a;
				y = b;
				while (y != 0) begin
					r = x % y;
					x = y;
					y = r;
				end
				ans.value = x[DATA_WIDTH-1:0];
			end
			CMD_FACT: begin
				// Zero and anything past the limit are faults.
				if (a == 0 || a > FACT_MAX) begin
					ans.error = 1'b1;
				end else begin
					x = 1;
					for (y = 2; y <= a; y++) x = x * y;
					if (x > wmask) ans.error = 1'b1;
					else ans.value = x[DATA_WIDTH-1:0];
				end
			end
			CMD_SQRT: begin
				// Newton-style estimate until the two guesses are within one.
				x       = a / 2;
				y       = 2;
				settled = 1'b0;
				for (n = 0; n < SQRT_MAX_ITER && !settled; n++) begin
					r = (y > x) ? (y - x) : (x - y);
					if (r <= 1) begin
						settled = 1'b1;
					end else begin
						y = (x + y) / 2;
						if (y == 0) settled = 1'b1;
						else x = a / y;
					end
				end
				ans.value = x[DATA_WIDTH-1:0];
			end
			default: begin
				ans.error = 1'b1;
			end
		endcase
		return ans;
	endfunction

	// Queue a prediction for each accepted request, then check each result.
	always @(posedge clk) begin : watch
		answer_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				answer_q.push_back(compute_answer(s_tuser, s_tdata[DATA_WIDTH-1:0],
					s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
			end
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					note_mismatch($sformatf("result %0d error %0b with no request waiting",
						m_tdata[DATA_WIDTH-1:0], m_tuser));
				end else begin
					want = answer_q.pop_front();
					if (m_tdata[DATA_WIDTH-1:0] !== want.value) begin
						note_mismatch($sformatf("cmd %0d a %0d b %0d: result %0d, wanted %0d",
							want.op, want.operand_a, want.operand_b,
							m_tdata[DATA_WIDTH-1:0], want.value));
					end
					if (m_tuser !== want.error) begin
						note_mismatch($sformatf("cmd %0d a %0d b %0d: error %0b, wanted %0b",
							want.op, want.operand_a, want.operand_b, m_tuser, want.error));
					end
				end
			end
			pending = answer_q.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer math unit testbench
// Drives gcd, factorial, square root and unknown-command requests in bursts,
// first a directed set of edge cases and then random ones, while the result
// side stalls on its own pattern. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import imu_pkg::*;

	localparam int unsigned         DATA_WIDTH   = 31;
	localparam int unsigned         S_W          = ((2*DATA_WIDTH+7)/8)*8;
	localparam int unsigned         M_W          = ((DATA_WIDTH+7)/8)*8;
	localparam logic [1:0]          CMD_UNKNOWN  = 2'd3;
	localparam logic [DATA_WIDTH-1:0] OPERAND_MAX = '1;
	localparam int                  RANDOM_ITEMS = 400;
	localparam int                  DRAIN_CYCLES = 1600;
	localparam longint              LIMIT_NS     = 35_000_000;

	typedef enum {READY_STEADY, READY_FLICKER, READY_BLOCKED} ready_mode_t;

	logic           clk      = 1'b0;
	logic           arst_n   = 1'b0;
	logic           s_tvalid = 1'b0;
	logic           s_tready;
	logic [S_W-1:0] s_tdata  = '0;
	logic [1:0]     s_tuser  = '0;
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;
	logic           m_tuser;
	int             mismatch_count;
	int             outstanding;
	int             burst_left = 0;
	int             ready_hold = 0;
	ready_mode_t    ready_mode = READY_STEADY;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	integer_math_unit #(
		.DATA_WIDTH(DATA_WIDTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	imu_result_checker #(
		.DATA_WIDTH(DATA_WIDTH)
	) result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// Result side: runs of steady ready, random flicker or a full block.
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			case ($urandom_range(0, 3))
				0, 1: ready_mode <= READY_STEADY;
				2: ready_mode <= READY_FLICKER;
				default: ready_mode <= READY_BLOCKED;
			endcase
			ready_hold <= $urandom_range(1, 40);
		end else begin
			ready_hold <= ready_hold - 1;
		end
		case (ready_mode)
			READY_STEADY: m_tready <= 1'b1;
			READY_FLICKER: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= 1'b0;
		endcase
	end

	// Offers one request and holds it until accepted; a gap opens each burst.
	task automatic send_request(
		input logic [1:0]            op,
		input logic [DATA_WIDTH-1:0] a,
		input logic [DATA_WIDTH-1:0] b
	);
		logic [S_W-1:0] word;
		int             gap;
		word                            = '0;
		word[DATA_WIDTH-1:0]            = a;
		word[2*DATA_WIDTH-1:DATA_WIDTH] = b;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 20);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	// Operand mix: full range, small values, edges and powers of two.
	function automatic logic [DATA_WIDTH-1:0] pick_operand();
		logic [DATA_WIDTH-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 9: v = DATA_WIDTH'($urandom());
			4, 5: v = DATA_WIDTH'($urandom_range(0, 255));
			6: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = 1;
					2: v = OPERAND_MAX;
					default: v = OPERAND_MAX - 1'b1;
				endcase
			end
			7: begin
				v = '0;
				v[$urandom_range(0, DATA_WIDTH-1)] = 1'b1;
				if ($urandom_range(0, 1)) v = v - 1'b1;
			end
			default: v = DATA_WIDTH'($urandom_range(0, 65535));
		endcase
		return v;
	endfunction

	initial begin
		int                    i;
		int                    pick;
		int unsigned           g;
		longint unsigned       f_lo;
		longint unsigned       f_hi;
		longint unsigned       f_next;
		logic [1:0]            op;
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: gcd zero cases, equal and coprime extremes, worst-case pair.
		send_request(CMD_GCD, '0, '0);
		send_request(CMD_GCD, 123456, '0);
		send_request(CMD_GCD, '0, 987654321);
		send_request(CMD_GCD, OPERAND_MAX, OPERAND_MAX);
		send_request(CMD_GCD, OPERAND_MAX, 1);
		send_request(CMD_GCD, 1836311903, 1134903170);
		send_request(CMD_GCD, 462, 1071);
		send_request(CMD_GCD, OPERAND_MAX, OPERAND_MAX - 1'b1);
		// Directed: factorial faults at zero and past the limit, and the limit.
		send_request(CMD_FACT, '0, '0);
		send_request(CMD_FACT, 1, '0);
		send_request(CMD_FACT, DATA_WIDTH'(FACT_MAX), '0);
		send_request(CMD_FACT, DATA_WIDTH'(FACT_MAX + 1), '0);
		send_request(CMD_FACT, OPERAND_MAX, OPERAND_MAX);
		send_request(CMD_FACT, 7, OPERAND_MAX);
		// Directed: square root of zero, one, small values and the maximum.
		send_request(CMD_SQRT, '0, OPERAND_MAX);
		send_request(CMD_SQRT, 1, '0);
		send_request(CMD_SQRT, 2, '0);
		send_request(CMD_SQRT, 3, '0);
		send_request(CMD_SQRT, 4, '0);
		send_request(CMD_SQRT, 99, '0);
		send_request(CMD_SQRT, OPERAND_MAX, '0);
		// Directed: the unknown command.
		send_request(CMD_UNKNOWN, OPERAND_MAX, OPERAND_MAX);
		send_request(CMD_UNKNOWN, '0, '0);

		// Random requests, weighted toward gcd and square root.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			a    = pick_operand();
			b    = DATA_WIDTH'($urandom());
			if (pick < 35) begin
				op = CMD_GCD;
				case ($urandom_range(0, 3))
					0: begin
						// Multiples of a common factor give non-trivial answers.
						g = $urandom_range(1, 5000);
						a = DATA_WIDTH'(g * $urandom_range(0, OPERAND_MAX / g));
						b = DATA_WIDTH'(g * $urandom_range(0, OPERAND_MAX / g));
					end
					1: begin
						// Consecutive Fibonacci numbers make the longest loops.
						f_lo = 0;
						f_hi = 1;
						repeat ($urandom_range(1, 45)) begin
							f_next = f_lo + f_hi;
							f_lo   = f_hi;
							f_hi   = f_next;
						end
						a = f_hi[DATA_WIDTH-1:0];
						b = f_lo[DATA_WIDTH-1:0];
						if ($urandom_range(0, 1)) begin
							a = f_lo[DATA_WIDTH-1:0];
							b = f_hi[DATA_WIDTH-1:0];
						end
					end
					default: begin
						b = pick_operand();
					end
				endcase
			end else if (pick < 55) begin
				op = CMD_FACT;
				if ($urandom_range(0, 3) != 0) begin
					a = DATA_WIDTH'($urandom_range(0, FACT_MAX + 3));
				end
			end else if (pick < 90) begin
				op = CMD_SQRT;
			end else begin
				op = CMD_UNKNOWN;
				b  = pick_operand();
			end
			send_request(op, a, b);
		end
		s_tvalid <= 1'b0;

		// Drain: every expected result in, then a quiet stretch.
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog against a hung unit.
	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
